### sv/sb2da_pkg.sv
// Package: constants, controller state and command/status types for the decimal text converter.
`default_nettype none
package sb2da_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;        // capture input word, start conversion
    logic conv_step;   // one shift-add-3 step
    logic skip_digit;  // drop a leading zero digit
    logic emit_sign;   // write '-' to the output register
    logic emit_digit;  // write top digit to the output register
  } cmd_t;

  typedef struct packed {
    logic step_last;   // current conversion step is the final one
    logic neg;         // captured word was negative
    logic top_zero;    // top remaining digit is zero
    logic digit_last;  // one digit remains
    logic out_free;    // output register can take a character this cycle
  } status_t;

endpackage
`default_nettype wire

### sv/sb2da_dp.sv
// Datapath: magnitude, BCD shift register, counters and output register.
`default_nettype none
module sb2da_dp #(
  parameter int VALUE_BITS = sb2da_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire sb2da_pkg::cmd_t       cmd,
  output sb2da_pkg::status_t         status,
  output logic [7:0]                 out_ascii_char,
  output logic                       out_last,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCDW = 4 * NDIG;
  localparam int BCW  = $clog2(VALUE_BITS + 1);
  localparam int DCW  = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCDW-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [BCW-1:0]        bitcnt_r, bitcnt_nxt;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [7:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic                  valid_r, valid_nxt;
  logic [3:0]            top_digit;

  assign top_digit = bcd_r[BCDW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt    = mag_r;
    bcd_nxt    = bcd_r;
    bitcnt_nxt = bitcnt_r;
    dcnt_nxt   = dcnt_r;
    neg_nxt    = neg_r;
    if (cmd.load) begin
      neg_nxt    = in_value[VALUE_BITS-1];
      mag_nxt    = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt    = '0;
      bitcnt_nxt = BCW'(VALUE_BITS);
      dcnt_nxt   = DCW'(NDIG);
    end else if (cmd.conv_step) begin
      bcd_nxt    = {bcd_adj[BCDW-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt    = {mag_r[VALUE_BITS-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r - 1'b1;
    end else if (cmd.skip_digit || cmd.emit_digit) begin
      bcd_nxt  = {bcd_r[BCDW-5:0], 4'd0};
      dcnt_nxt = dcnt_r - 1'b1;
    end
  end

  always_comb begin
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    if (cmd.emit_sign) begin
      char_nxt  = sb2da_pkg::ASCII_MINUS;
      last_nxt  = 1'b0;
      valid_nxt = 1'b1;
    end else if (cmd.emit_digit) begin
      char_nxt  = sb2da_pkg::ASCII_ZERO + {4'd0, top_digit};
      last_nxt  = status.digit_last;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    bcd_r    <= bcd_nxt;
    bitcnt_r <= bitcnt_nxt;
    dcnt_r   <= dcnt_nxt;
    neg_r    <= neg_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign status.step_last  = (bitcnt_r == BCW'(1));
  assign status.neg        = neg_r;
  assign status.top_zero   = (top_digit == 4'd0);
  assign status.digit_last = (dcnt_r == DCW'(1));
  assign status.out_free   = !valid_r || out_ready;

  assign out_ascii_char = char_r;
  assign out_last       = last_r;
  assign out_valid      = valid_r;

endmodule
`default_nettype wire

### sv/sb2da_ctrl.sv
// Controller: sequences load, conversion, leading-zero skip and character output.
`default_nettype none
module sb2da_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sb2da_pkg::status_t status,
  output sb2da_pkg::cmd_t         cmd
);

  sb2da_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sb2da_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sb2da_pkg::ST_CONV;
      end
      sb2da_pkg::ST_CONV: begin
        if (status.step_last) state_nxt = sb2da_pkg::ST_SKIP;
      end
      sb2da_pkg::ST_SKIP: begin
        if (!status.top_zero || status.digit_last) begin
          state_nxt = status.neg ? sb2da_pkg::ST_SIGN : sb2da_pkg::ST_DIGITS;
        end
      end
      sb2da_pkg::ST_SIGN: begin
        if (status.out_free) state_nxt = sb2da_pkg::ST_DIGITS;
      end
      sb2da_pkg::ST_DIGITS: begin
        if (status.out_free && status.digit_last) state_nxt = sb2da_pkg::ST_IDLE;
      end
      default: state_nxt = sb2da_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sb2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sb2da_pkg::ST_CONV:   cmd.conv_step  = 1'b1;
      sb2da_pkg::ST_SKIP:   cmd.skip_digit = status.top_zero && !status.digit_last;
      sb2da_pkg::ST_SIGN:   cmd.emit_sign  = status.out_free;
      sb2da_pkg::ST_DIGITS: cmd.emit_digit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sb2da_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/signed_binary_to_decimal_ascii.sv
// A taken word is converted to BCD bit-serially, then leading zero digits are dropped
// (up to NDIG-1); then one character per cycle is sent when out_ready is high.
// Only one word is in flight at a time: the next word is taken once the last character
// sits in the output register. Reset (synchronous, rst_n low) idles the controller and
// empties the output register.
`default_nettype none
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = sb2da_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_ascii_char,
  output logic                       out_last
);

  sb2da_pkg::cmd_t    cmd;
  sb2da_pkg::status_t status;

  sb2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sb2da_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .status         (status),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule
`default_nettype wire

### dv/signed_binary_to_decimal_ascii_test.sv
// Self-checking testbench for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii_test;

  localparam int          WORD_BITS  = 32;
  localparam logic [31:0] RADIX      = 32'd10;
  localparam int          RANDOM_WORDS = 350;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WORD_BITS-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_ascii_char;
  logic                 out_last;

  logic [WORD_BITS-1:0] pending_words[$];
  text_char_t           expected_chars[$];

  int errors = 0;
  int words_sent = 0;
  int negative_words = 0;
  int chars_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  signed_binary_to_decimal_ascii #(.VALUE_BITS(WORD_BITS)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last      (out_last)
  );

  always #4 clk = ~clk;

  // Expected text: optional minus, then digits most significant first.
  task automatic queue_decimal_text(input logic [WORD_BITS-1:0] word);
    logic [31:0] mag;
    logic [7:0]  digits[$];
    text_char_t  c;
    mag = word[WORD_BITS-1] ? (~word + 32'd1) : word;
    do begin
      digits.push_front(sb2da_pkg::ASCII_ZERO + 8'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (word[WORD_BITS-1]) begin
      c.ch = sb2da_pkg::ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      negative_words++;
    end
    foreach (digits[i]) begin
      c.ch = digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s at char %0d: got %0d, expected %0d",
             $time, what, chars_seen, got, want);
    errors++;
  endtask

  function automatic logic [WORD_BITS-1:0] random_word();
    int unsigned ndig, lo, hi;
    logic [WORD_BITS-1:0] w;
    case ($urandom_range(5))
      0, 1: w = $urandom;
      2: w = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                               : 32'h7FFF_FFFF - $urandom_range(15);
      default: begin
        ndig = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (ndig == 1) lo = 0;
        w = $urandom_range(hi, lo);
        if ($urandom_range(1)) w = -w;
      end
    endcase
    return w;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_decimal_text(in_value);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 &&
            ((words_sent >= 150 && words_sent < 230) || $urandom_range(99) >= 11)) begin
          in_valid <= 1'b1;
          in_value <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected word", out_ascii_char, -1);
        end else begin
          want = expected_chars.pop_front();
          if (out_ascii_char !== want.ch) report_mismatch("ascii_char", out_ascii_char, want.ch);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
        chars_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && chars_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (chars_seen >= 1200 && chars_seen < 1700) || $urandom_range(99) >= 11;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word accepted in %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    pending_words = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10, 32'd99,
                      32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                      32'd1000000000, -32'd999999999, 32'd1999999999, 32'd123456789,
                      -32'd9, 32'd5, -32'd100000, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (RANDOM_WORDS) pending_words.push_back(random_word());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d words (%0d negative) into %0d characters,",
             words_sent, negative_words, chars_seen);
    $display("including both extremes, zero and a %0d-cycle output stall.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/sb2da_pkg.sv
sv/sb2da_dp.sv
sv/sb2da_ctrl.sv
sv/signed_binary_to_decimal_ascii.sv
dv/signed_binary_to_decimal_ascii_test.sv
